FILE: hdl/rmsn_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rmsn_pkg
// Shared types, constants and helpers for the rms normalization block.
// ---------------------------------------------------------------------------
package rmsn_pkg;

  localparam int MAX_DIM      = 64;
  localparam int DIV_STEPS    = 53;  // quotient bits of the shared divider
  localparam int SQRT_STEPS   = 27;  // root bits of the square root unit
  localparam int DIV_W        = 53;
  localparam int DEN_W        = 38;
  localparam int ROOT_W       = 27;

  localparam logic [0:0] REG_ROW_LENGTH = 1'b0;
  localparam logic [0:0] REG_EPSILON    = 1'b1;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_CLOSE,
    ST_DIV_MEAN,
    ST_DIV_RECIP,
    ST_SQRT,
    ST_READ,
    ST_MUL_X,
    ST_MUL_G,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic mean_init;
    logic div_step;
    logic recip_init;
    logic sqrt_step;
    logic emit_init;
    logic read_elem;
    logic mul_x;
    logic mul_g;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic closing;
    logic iter_done;
    logic last_elem;
    logic out_free;
  } status_t;

  function automatic logic signed [15:0] sat16(input logic signed [41:0] v);
    logic signed [15:0] r;
    if (v > 42'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -42'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/rms_norm_forward.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rms_norm_forward
// RMS normalization forward pass in fixed point, one row element per word.
//
//   channel | signals                                   | dir
//   in      | in_valid, in_stall, sample, gain_value    | in
//   out     | out_valid, out_stall, normalized, scaled, | out
//           | inverse_rms, position, row_done           |
//   cfg     | psel, penable, pwrite, paddr, pwdata,     | in/out
//           | prdata, pready                            |
//
// elements are taken one per cycle until the row is full; closing the row
// runs two passes of the bit-serial divider and then the root unit, each
// with a handoff step, then each result passes through memory read and the
// two multipliers into the output word, which waits while out_stall holds.
// reset clears the sequencer, row count and sum; row_length 64, epsilon 168.
// ---------------------------------------------------------------------------
module rms_norm_forward import rmsn_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] sample,
  input  wire logic signed [15:0] gain_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [15:0] normalized,
  output logic signed      [15:0] scaled,
  output logic             [23:0] inverse_rms,
  output logic             [5:0]  position,
  output logic                    row_done,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic        [2:0]  paddr,
  input  wire logic        [31:0] pwdata,
  output logic             [31:0] prdata,
  output logic                    pready
);

  logic [6:0]  row_length;
  logic [23:0] epsilon;
  cmd_t        cmd;
  status_t     status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= 7'd64;
      epsilon    <= 24'd168;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_ROW_LENGTH: row_length <= pwdata[6:0];
        REG_EPSILON:    epsilon    <= pwdata[23:0];
        default:        row_length <= row_length;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROW_LENGTH: prdata = {25'd0, row_length};
      REG_EPSILON:    prdata = {8'd0, epsilon};
      default:        prdata = '0;
    endcase
  end

  rmsn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rmsn_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .row_length  (row_length),
    .epsilon     (epsilon),
    .sample      (sample),
    .gain_value  (gain_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .normalized  (normalized),
    .scaled      (scaled),
    .inverse_rms (inverse_rms),
    .position    (position),
    .row_done    (row_done)
  );

endmodule
`default_nettype wire

FILE: hdl/rmsn_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rmsn_ctrl
// Sequencer: collects a row, runs mean, reciprocal and root, then emits.
// ---------------------------------------------------------------------------
module rmsn_ctrl import rmsn_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (in_valid && status.closing) state_next = ST_CLOSE;
      end
      ST_CLOSE:     state_next = ST_DIV_MEAN;
      ST_DIV_MEAN: begin
        if (status.iter_done) state_next = ST_DIV_RECIP;
      end
      ST_DIV_RECIP: begin
        if (status.iter_done) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (status.iter_done) state_next = ST_READ;
      end
      ST_READ:      state_next = ST_MUL_X;
      ST_MUL_X:     state_next = ST_MUL_G;
      ST_MUL_G:     state_next = ST_LOAD;
      ST_LOAD: begin
        if (status.out_free) state_next = status.last_elem ? ST_COLLECT : ST_READ;
      end
      default:      state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_COLLECT: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_CLOSE:     cmd.mean_init = 1'b1;
      ST_DIV_MEAN: begin
        cmd.recip_init = status.iter_done;
        cmd.div_step   = !status.iter_done;
      end
      ST_DIV_RECIP: begin
        cmd.div_step  = !status.iter_done;
        // starting the root unit also loads its counter
        cmd.sqrt_step = 1'b0;
      end
      ST_SQRT: begin
        cmd.emit_init = status.iter_done;
        cmd.sqrt_step = !status.iter_done;
      end
      ST_READ:      cmd.read_elem = 1'b1;
      ST_MUL_X:     cmd.mul_x     = 1'b1;
      ST_MUL_G:     cmd.mul_g     = 1'b1;
      ST_LOAD:      cmd.load_out  = status.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/rmsn_dpath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rmsn_dpath
// Row buffer, square sum, shared divider, root unit, multipliers, output word.
// ---------------------------------------------------------------------------
module rmsn_dpath import rmsn_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire logic        [6:0]  row_length,
  input  wire logic        [23:0] epsilon,
  input  wire logic signed [15:0] sample,
  input  wire logic signed [15:0] gain_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [15:0] normalized,
  output logic signed      [15:0] scaled,
  output logic             [23:0] inverse_rms,
  output logic             [5:0]  position,
  output logic                    row_done
);

  logic [31:0] row_mem [MAX_DIM];
  logic [31:0] rd_data;

  logic [6:0]  count;
  logic [36:0] square_sum;
  logic [6:0]  eff_len;
  logic [6:0]  count_inc;

  logic [DIV_W-1:0]  quo;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dvsr;
  logic [DEN_W:0]    rem_shift;
  logic [DEN_W-1:0]  mean_eps;
  logic [5:0]        iter_cnt;

  logic [DIV_W:0]    sq_q;
  logic [29:0]       sq_rem;
  logic [ROOT_W-1:0] sq_root;
  logic [29:0]       sq_try;
  logic [29:0]       sq_trial;

  // root unit starts right after the reciprocal quotient is complete
  logic sq_load_pending;
  logic div_recip_run;

  logic [23:0]        inv;
  logic [5:0]         pos;
  logic signed [40:0] prod_x;
  logic signed [15:0] nv_comb;
  logic signed [15:0] nv;
  logic signed [31:0] prod_g;
  logic signed [15:0] sv_comb;
  logic signed [31:0] square;

  assign eff_len = (row_length == 7'd0) ? 7'd1 :
                   (row_length > 7'(MAX_DIM)) ? 7'(MAX_DIM) : row_length;
  assign count_inc = count + 7'd1;
  assign square    = sample * sample;

  assign status.closing   = (count_inc >= eff_len);
  assign status.iter_done = (iter_cnt == 6'd0);
  assign status.last_elem = ({1'b0, pos} + 7'd1 == count);
  assign status.out_free  = !out_valid || !out_stall;

  // row buffer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_mem[count[5:0]] <= {sample, gain_value};
    end
    if (cmd.read_elem) begin
      rd_data <= row_mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      square_sum <= '0;
    end else if (cmd.accept) begin
      count      <= count_inc;
      square_sum <= square_sum + {5'd0, square[31:0]};
    end else if (cmd.load_out && status.last_elem) begin
      count      <= '0;
      square_sum <= '0;
    end
  end

  // restoring divider, one quotient bit per cycle; a zero divisor gives all
  // ones, whose root then saturates inverse_rms as required
  assign rem_shift = {rem, quo[DIV_W-1]};
  assign mean_eps  = {1'b0, quo[36:0]} + {14'd0, epsilon};

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_cnt <= '0;
    end else if (cmd.mean_init || cmd.recip_init) begin
      iter_cnt <= 6'(DIV_STEPS);
    end else if (cmd.div_step || cmd.sqrt_step) begin
      iter_cnt <= iter_cnt - 6'd1;
    end else if (!cmd.emit_init && iter_cnt == 6'd0 && sq_load_pending) begin
      iter_cnt <= 6'(SQRT_STEPS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_recip_run <= 1'b0;
    end else if (cmd.recip_init) begin
      div_recip_run <= 1'b1;
    end else if (div_recip_run && iter_cnt == 6'd0) begin
      div_recip_run <= 1'b0;
    end
  end
  assign sq_load_pending = div_recip_run;

  always_ff @(posedge clk) begin
    if (cmd.mean_init) begin
      quo  <= {16'd0, square_sum};
      rem  <= '0;
      dvsr <= {31'd0, count};
    end else if (cmd.recip_init) begin
      quo  <= {1'b1, {(DIV_W-1){1'b0}}};
      rem  <= '0;
      dvsr <= mean_eps;
    end else if (cmd.div_step) begin
      if (rem_shift >= {1'b0, dvsr}) begin
        rem <= DEN_W'(rem_shift - {1'b0, dvsr});
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DEN_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  // digit-by-digit square root, two radicand bits per cycle
  assign sq_try   = {sq_rem[27:0], sq_q[DIV_W:DIV_W-1]};
  assign sq_trial = {1'b0, sq_root, 2'b01};

  always_ff @(posedge clk) begin
    if (div_recip_run && iter_cnt == 6'd0) begin
      sq_q    <= {1'b0, quo};
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sqrt_step) begin
      sq_q <= {sq_q[DIV_W-2:0], 2'b00};
      if (sq_try >= sq_trial) begin
        sq_rem  <= sq_try - sq_trial;
        sq_root <= {sq_root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem  <= sq_try;
        sq_root <= {sq_root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // emission
  assign nv_comb = sat16(42'((prod_x + 41'sd8192) >>> 14));
  assign sv_comb = sat16(42'((33'(prod_g) + 33'sd2048) >>> 12));

  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      inv <= (sq_root > ROOT_W'(24'hffffff)) ? 24'hffffff : sq_root[23:0];
    end
    if (cmd.emit_init) begin
      pos <= '0;
    end else if (cmd.load_out) begin
      pos <= pos + 6'd1;
    end
    if (cmd.mul_x) begin
      prod_x <= $signed(rd_data[31:16]) * $signed({1'b0, inv});
    end
    if (cmd.mul_g) begin
      nv     <= nv_comb;
      prod_g <= $signed(rd_data[15:0]) * nv_comb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      normalized  <= nv;
      scaled      <= sv_comb;
      inverse_rms <= inv;
      position    <= pos;
      row_done    <= status.last_elem;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 7'(MAX_DIM))
    else $error("row count beyond buffer depth");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(normalized) && $stable(position))
    else $error("stalled word changed");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded word not presented");

  a_row_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out && status.last_elem |=> count == 7'd0)
    else $error("row state not cleared after last word");

endmodule
`default_nettype wire
